// ----- hdl/bmpu_pkg.sv -----
// ----------------------------------------------------------------------------
// bmpu_pkg: shared types and constants of the banked memory paging unit
// Machine models, action codes, port decodes, bank codes and the layout of
// the result word.
// ----------------------------------------------------------------------------
package bmpu_pkg;

    // Physical bank: 0-7 ROM pages, 8-15 RAM pages 0-7.
    typedef logic [3:0] t_bank;

    // Machine models.
    localparam logic [1:0] MODEL_48K_EARLY = 2'd0;
    localparam logic [1:0] MODEL_48K_LATE  = 2'd1;
    localparam logic [1:0] MODEL_128K      = 2'd2;
    localparam logic [1:0] MODEL_PLUS3     = 2'd3;

    // Input actions.
    localparam logic [1:0] ACT_PORT_WR = 2'd0;
    localparam logic [1:0] ACT_MEM_RD  = 2'd1;
    localparam logic [1:0] ACT_MEM_WR  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MACHINE_MODEL = 1'b0;
    localparam logic CFG_RAM_TOP       = 1'b1;

    localparam int CFG_W = 17;

    // Port decodes.
    localparam logic [15:0] PG128_MASK  = 16'h8002;
    localparam logic [15:0] PG128_MATCH = 16'h0000;
    localparam logic [15:0] PGP3_MASK   = 16'hC002;
    localparam logic [15:0] PGP3_MATCH  = 16'h4000;
    localparam logic [15:0] P3L_MASK    = 16'hF002;
    localparam logic [15:0] P3L_MATCH   = 16'h1000;

    // Latch bits.
    localparam int PG_SCREEN_BIT = 3;
    localparam int PG_ROM_BIT    = 4;
    localparam int PG_LOCK_BIT   = 5;
    localparam int P3_SPECIAL_BIT = 0;
    localparam int P3_ROM_BIT     = 2;
    localparam int P3_MOTOR_BIT   = 3;

    // Reset values.
    localparam logic [1:0]       MODEL_RESET   = MODEL_48K_LATE;
    localparam logic [CFG_W-1:0] RAM_TOP_RESET = 17'h10000;

    // Fixed banks.
    localparam t_bank BANK_ROM0 = 4'd0;
    localparam t_bank BANK_RAM0 = 4'd8;
    localparam t_bank BANK_RAM2 = 4'd10;
    localparam t_bank BANK_RAM5 = 4'd13;
    localparam t_bank BANK_RAM7 = 4'd15;

    // Result word layout, from the lowest bit up.
    localparam int OUT_BANK_LSB   = 0;
    localparam int OUT_OFS_LSB    = 4;
    localparam int OUT_OK_BIT     = 18;
    localparam int OUT_SCR_LSB    = 19;
    localparam int OUT_MOTOR_BIT  = 23;
    localparam int OUT_LOCK_BIT   = 24;
    localparam int OUT_USED_W     = 25;
    localparam int OUT_W          = 32;
    localparam int IN_W           = 24;

    // RAM page to physical bank.
    function automatic t_bank ram_bank(input logic [2:0] page);
        ram_bank = {1'b1, page};
    endfunction

    // Bank of one slot in the special all-RAM modes.
    function automatic t_bank special_bank(input logic [1:0] mode, input logic [1:0] slot);
        logic [2:0] page;
        case (mode)
            2'd0: begin
                page = {1'b0, slot};
            end
            2'd1: begin
                page = {1'b1, slot};
            end
            2'd2: begin
                page = (slot == 2'd3) ? 3'd3 : {1'b1, slot};
            end
            default: begin
                case (slot)
                    2'd0:    page = 3'd4;
                    2'd1:    page = 3'd7;
                    2'd2:    page = 3'd6;
                    default: page = 3'd3;
                endcase
            end
        endcase
        special_bank = ram_bank(page);
    endfunction

endpackage

// ----- hdl/banked_memory_paging_unit.sv -----
// ----------------------------------------------------------------------------
// banked_memory_paging_unit: CPU address translation through four 16K slots
// Decodes paging port writes, keeps the paging and plus3 latches and the
// bank map, and translates memory accesses into bank and offset.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one transfer per CPU bus cycle. tuser carries
//   the action (port write, memory read, memory write), tdata the address
//   and the port data byte.
//   Output stream (m_axis_*): exactly one result transfer per input transfer,
//   in order: bank, offset, access grant, and the screen bank, motor and lock
//   state as they stand after the item.
//   The result of an accepted item is registered in the output register, or
//   in the skid register while the receiver stalls. Throughput is one item
//   per cycle while the receiver takes results, set by the single registered
//   translation stage; latch updates take effect for the very next item.
//   When the receiver stalls, the output register holds its result and a
//   skid register takes one more item; s_axis_tready falls only while both
//   are full.
//   Reset (synchronous, active low) clears both latches, restores the map to
//   ROM 0, RAM 5, RAM 2, RAM 0 with the screen in RAM 5, sets the model to
//   the later 48K and ram_top to 65536, and empties the output stage.
//   Configuration writes take effect at the clock edge where i_cfg_we is high.
// ----------------------------------------------------------------------------
module banked_memory_paging_unit
    import bmpu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Configuration write port.
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    // Input stream.
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // addr[15:0], data[23:16]
    input  logic [1:0]       s_axis_tuser,   // action[1:0]
    // Output stream.
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // phys_bank[3:0], bank_offset[17:4],
                                             // access_ok[18], screen_bank[22:19],
                                             // motor_on[23], paging_locked[24]
);

    // Configuration registers.
    logic [1:0]       r_model;
    logic [CFG_W-1:0] r_ram_top;

    // Paging state.
    logic [7:0] r_paging;
    logic [7:0] r_plus3;
    t_bank      r_map [4];
    t_bank      r_screen;

    // Next state.
    logic [7:0] n_paging;
    logic [7:0] n_plus3;
    t_bank      n_map [4];
    t_bank      n_screen;

    // Output stage and skid register.
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;
    logic             r_skid_valid;
    logic [OUT_W-1:0] r_skid_data;

    logic [1:0]       in_action;
    logic [15:0]      in_addr;
    logic [7:0]       in_data;
    logic             in_xfer;
    logic             out_free;
    logic             port_wr;
    logic             mem_acc;
    logic             pg_load;
    logic             p3_hit;
    logic             rebuild;
    t_bank            res_bank;
    logic             res_ok;
    logic [OUT_W-1:0] res_word;

    assign in_action = s_axis_tuser;
    assign in_addr   = s_axis_tdata[15:0];
    assign in_data   = s_axis_tdata[23:16];

    assign s_axis_tready = !r_skid_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // Port decode and latch loads.
    always_comb begin
        port_wr = (in_action == ACT_PORT_WR);
        mem_acc = (in_action == ACT_MEM_RD) || (in_action == ACT_MEM_WR);
        pg_load = port_wr && !r_paging[PG_LOCK_BIT] &&
                  (((r_model == MODEL_128K) && ((in_addr & PG128_MASK) == PG128_MATCH)) ||
                   ((r_model == MODEL_PLUS3) && ((in_addr & PGP3_MASK) == PGP3_MATCH)));
        p3_hit  = port_wr && (r_model == MODEL_PLUS3) &&
                  ((in_addr & P3L_MASK) == P3L_MATCH);
        rebuild = pg_load || p3_hit;
        n_paging = pg_load ? in_data : r_paging;
        n_plus3  = p3_hit ? in_data : r_plus3;
    end

    // Map rebuild from the new latch values.
    always_comb begin
        n_map[0] = r_map[0];
        n_map[1] = BANK_RAM5;
        n_map[2] = BANK_RAM2;
        n_map[3] = ram_bank(n_paging[2:0]);
        n_screen = n_paging[PG_SCREEN_BIT] ? BANK_RAM7 : BANK_RAM5;
        if (r_model == MODEL_128K) begin
            n_map[0] = {3'b000, n_paging[PG_ROM_BIT]};
        end
        if (r_model == MODEL_PLUS3) begin
            n_map[0] = {2'b00, n_plus3[P3_ROM_BIT], n_paging[PG_ROM_BIT]};
            if (n_plus3[P3_SPECIAL_BIT]) begin
                for (int s = 0; s < 4; s++) begin
                    n_map[s] = special_bank(n_plus3[2:1], 2'(s));
                end
            end
        end
    end

    // Translation of a memory access through the current map.
    always_comb begin
        res_bank = mem_acc ? r_map[in_addr[15:14]] : BANK_ROM0;
        res_ok   = mem_acc && ({1'b0, in_addr} < r_ram_top) &&
                   !((in_action == ACT_MEM_WR) && !res_bank[3]);
        res_word = '0;
        res_word[OUT_BANK_LSB +: 4]  = res_bank;
        res_word[OUT_OFS_LSB +: 14]  = mem_acc ? in_addr[13:0] : 14'd0;
        res_word[OUT_OK_BIT]         = res_ok;
        res_word[OUT_SCR_LSB +: 4]   = rebuild ? n_screen : r_screen;
        res_word[OUT_MOTOR_BIT]      = n_plus3[P3_MOTOR_BIT];
        res_word[OUT_LOCK_BIT]       = n_paging[PG_LOCK_BIT];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model   <= MODEL_RESET;
            r_ram_top <= RAM_TOP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MACHINE_MODEL: r_model   <= i_cfg_data[1:0];
                CFG_RAM_TOP:       r_ram_top <= i_cfg_data;
                default:           r_model   <= r_model;
            endcase
        end
    end

    // Latches, updated on each accepted transfer; bank map and screen bank, rebuilt when a latch loads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paging <= 8'd0;
            r_plus3  <= 8'd0;
            r_map[0] <= BANK_ROM0;
            r_map[1] <= BANK_RAM5;
            r_map[2] <= BANK_RAM2;
            r_map[3] <= BANK_RAM0;
            r_screen <= BANK_RAM5;
        end else if (in_xfer) begin
            r_paging <= n_paging;
            r_plus3  <= n_plus3;
            if (rebuild) begin
                r_map    <= n_map;
                r_screen <= n_screen;
            end
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_xfer;
            end
        end else if (in_xfer) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (in_xfer) begin
                r_out_data <= res_word;
            end
        end else if (in_xfer) begin
            r_skid_data <= res_word;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- hdl/bmpu_checker.sv -----
// ----------------------------------------------------------------------------
// bmpu_checker: port-level assertions for the banked memory paging unit
// Watches the streams of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module bmpu_checker
    import bmpu_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata    // phys_bank, bank_offset, access_ok,
                                            // screen_bank, motor_on, paging_locked
);

    // Reset empties the output stage and opens the input.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("output stage not empty after reset");

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Every accepted transfer leaves a result waiting in the next cycle.
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted transfer produced no result");

    // The input only closes while a result waits in the output register.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input closed with output register empty");

    // The display file lives in RAM page 5 or 7, and the padding stays clear.
    a_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[OUT_SCR_LSB +: 4] == BANK_RAM5) ||
                           (m_axis_tdata[OUT_SCR_LSB +: 4] == BANK_RAM7)) &&
                          (m_axis_tdata[OUT_W-1:OUT_USED_W] == '0))
        else $error("bad screen bank or padding in result");

endmodule

bind banked_memory_paging_unit bmpu_checker u_bmpu_checker (.*);
